### src/pba_pkg.sv
`default_nettype none
package pba_pkg;

    localparam int POOL_BYTES  = 512;
    localparam int MAX_ENTRIES = 128;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int POS_W       = $clog2(POOL_BYTES) + 1;
    localparam int SZ_W        = POS_W + 1;
    localparam int AR_W        = SZ_W + 2;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_FND  = 2'd2;

    typedef struct packed {
        logic [SZ_W-1:0]  size;
        logic             inv;
        logic [POS_W-1:0] start;
    } t_desc;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_RD_I,
        OP_RD_J,
        OP_FIND,
        OP_FREE,
        OP_SHRINK,
        OP_GROW,
        OP_HSTART,
        OP_HNEXT,
        OP_ASTART,
        OP_AEV,
        OP_APPEND,
        OP_COMMIT,
        OP_MOVEFIN,
        OP_NOTFOUND
    } t_op;

    typedef struct packed {
        t_op  op;
        logic skip;
    } t_cmd;

    typedef struct packed {
        logic idx_end;
        logic jdx_end;
        logic hit;
        logic brk;
        logic over;
        logic touch;
        logic shrink_ok;
        logic ok;
    } t_stat;

endpackage
`default_nettype wire

### src/pba_ctrl.sv
`default_nettype none
module pba_ctrl
    import pba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [1:0] i_action,
    output logic            o_stall,
    output logic            o_valid,
    input  wire logic       i_stall,
    input  wire t_stat      i_st,
    output t_cmd            o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE = 16'h0001,
        S_FRD  = 16'h0002,
        S_FEV  = 16'h0004,
        S_FREE = 16'h0008,
        S_RSZ  = 16'h0010,
        S_GROW = 16'h0020,
        S_HRD  = 16'h0040,
        S_HEV  = 16'h0080,
        S_AST  = 16'h0100,
        S_ARD  = 16'h0200,
        S_AEV  = 16'h0400,
        S_ACHK = 16'h0800,
        S_APP  = 16'h1000,
        S_CMT  = 16'h2000,
        S_MFIN = 16'h4000,
        S_OUT  = 16'h8000
    } t_state;

    t_state r_state, n_state;
    logic   r_resize, n_resize;
    logic   r_mv, n_mv;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_resize <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_resize <= n_resize;
            r_mv     <= n_mv;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_resize   = r_resize;
        n_mv       = r_mv;
        o_cmd.op   = OP_NONE;
        // the in-place grow scan ignores the block being resized
        o_cmd.skip = r_resize && !r_mv;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_resize = (i_action == ACT_RESIZE);
                    n_mv     = 1'b0;
                    case (i_action)
                        ACT_ALLOC:              n_state = S_ARD;
                        ACT_FREE, ACT_RESIZE:   n_state = S_FRD;
                        default:                n_state = S_OUT;
                    endcase
                end
            end
            S_FRD: begin
                if (i_st.idx_end) begin
                    o_cmd.op = OP_NOTFOUND;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_FEV;
                end
            end
            S_FEV: begin
                o_cmd.op = OP_FIND;
                if (i_st.hit) n_state = r_resize ? S_RSZ : S_FREE;
                else          n_state = S_FRD;
            end
            S_FREE: begin
                o_cmd.op = OP_FREE;
                n_state  = S_OUT;
            end
            S_RSZ: begin
                if (i_st.shrink_ok) begin
                    o_cmd.op = OP_SHRINK;
                    n_state  = S_OUT;
                end else begin
                    o_cmd.op = OP_HSTART;
                    n_state  = S_HRD;
                end
            end
            S_GROW: begin
                o_cmd.op = OP_GROW;
                n_state  = S_OUT;
            end
            S_HRD: begin
                if (i_st.jdx_end) begin
                    n_state = (r_resize && !r_mv) ? S_GROW : S_CMT;
                end else begin
                    o_cmd.op = OP_RD_J;
                    n_state  = S_HEV;
                end
            end
            S_HEV: begin
                o_cmd.op = OP_HNEXT;
                if (i_st.touch) begin
                    if (r_resize && !r_mv) begin
                        n_mv    = 1'b1;
                        n_state = S_AST;
                    end else begin
                        n_state = S_ARD;
                    end
                end else begin
                    n_state = S_HRD;
                end
            end
            S_AST: begin
                o_cmd.op = OP_ASTART;
                n_state  = S_ARD;
            end
            S_ARD: begin
                if (i_st.idx_end) begin
                    n_state = S_APP;
                end else begin
                    o_cmd.op = OP_RD_I;
                    n_state  = S_AEV;
                end
            end
            S_AEV: begin
                o_cmd.op = OP_AEV;
                n_state  = i_st.brk ? S_ACHK : S_ARD;
            end
            S_ACHK: begin
                if (i_st.over) begin
                    n_state = S_ARD;
                end else begin
                    o_cmd.op = OP_HSTART;
                    n_state  = S_HRD;
                end
            end
            S_APP: begin
                o_cmd.op = OP_APPEND;
                n_state  = S_MFIN;
            end
            S_CMT: begin
                o_cmd.op = OP_COMMIT;
                n_state  = S_MFIN;
            end
            S_MFIN: begin
                if (r_mv && i_st.ok) o_cmd.op = OP_MOVEFIN;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

### src/pba_dpath.sv
`default_nettype none
module pba_dpath
    import pba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [1:0] i_action,
    input  wire logic [8:0] i_block_offset,
    input  wire logic [9:0] i_req_size,
    output t_stat           o_st,
    output logic [1:0]      o_status,
    output logic [8:0]      o_result_offset,
    output logic            o_moved,
    output logic [9:0]      o_copy_bytes
);

    typedef logic signed [AR_W-1:0] t_ar;

    function automatic logic spans_touch(t_ar as_, t_ar asz, t_ar bs, t_ar bsz);
        t_ar ae;
        t_ar be;
        ae = as_ + asz - t_ar'(1);
        be = bs + bsz - t_ar'(1);
        return (as_ <= bs && bs <= ae) || (as_ <= be && be <= ae) ||
               (bs <= as_ && as_ <= be) || (bs <= ae && ae <= be);
    endfunction

    t_desc r_mem [MAX_ENTRIES];
    t_desc r_rd;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [POS_W-1:0] r_dend, n_dend;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_jdx, n_jdx;
    logic [8:0]       r_off, n_off;
    logic [SZ_W-1:0]  r_sz, n_sz;
    logic [SZ_W-1:0]  r_prev, n_prev;
    logic [SZ_W-1:0]  r_cand, n_cand;
    logic             r_reuse_v, n_reuse_v;
    logic [IDX_W-1:0] r_reuse, n_reuse;
    logic [IDX_W-1:0] r_k, n_k;
    logic [POS_W-1:0] r_st, n_st;
    logic [SZ_W-1:0]  r_old, n_old;
    logic [1:0]       r_status, n_status;
    logic [8:0]       r_res, n_res;
    logic             r_moved, n_moved;
    logic [9:0]       r_copy, n_copy;

    logic             we;
    logic [IDX_W-1:0] wa;
    t_desc            wd;
    logic [IDX_W-1:0] ra;

    t_ar lim_next, lim_cur, e_grow, span_s;
    logic fit, app_fail, cmt_fail, grow_fail;

    assign lim_cur  = t_ar'(POOL_BYTES) - t_ar'({r_cnt, 2'b00});
    assign lim_next = lim_cur - t_ar'(4);
    assign e_grow   = t_ar'(r_st) + t_ar'(r_sz);
    assign span_s   = i_cmd.skip ? t_ar'(r_st) : t_ar'(r_cand);
    assign fit      = t_ar'(r_rd.start) >= t_ar'(r_prev) + t_ar'(r_sz);
    assign app_fail = (t_ar'(r_dend) + t_ar'(r_sz) > lim_next) ||
                      (!r_reuse_v && r_cnt >= CNT_W'(MAX_ENTRIES));
    assign cmt_fail = (t_ar'(r_dend) >= lim_next) || (r_cnt >= CNT_W'(MAX_ENTRIES));
    assign grow_fail = (e_grow > t_ar'(r_dend)) && (e_grow > lim_cur);

    always_comb begin
        o_st.idx_end   = (r_idx == r_cnt);
        o_st.jdx_end   = (r_jdx == r_cnt);
        o_st.hit       = !r_rd.inv && (r_rd.start == {1'b0, r_off});
        o_st.brk       = r_rd.inv || fit;
        o_st.over      = t_ar'(r_cand) + t_ar'(r_sz) > t_ar'(r_dend);
        o_st.touch     = !r_rd.inv && !(i_cmd.skip && r_jdx[IDX_W-1:0] == r_k) &&
                         spans_touch(span_s, t_ar'(r_sz), t_ar'(r_rd.start),
                                     t_ar'(r_rd.size));
        o_st.shrink_ok = (r_old >= r_sz);
        o_st.ok        = (r_status == ST_OK);
    end

    assign ra = (i_cmd.op == OP_RD_J) ? r_jdx[IDX_W-1:0] : r_idx[IDX_W-1:0];

    always_comb begin
        n_cnt     = r_cnt;
        n_dend    = r_dend;
        n_idx     = r_idx;
        n_jdx     = r_jdx;
        n_off     = r_off;
        n_sz      = r_sz;
        n_prev    = r_prev;
        n_cand    = r_cand;
        n_reuse_v = r_reuse_v;
        n_reuse   = r_reuse;
        n_k       = r_k;
        n_st      = r_st;
        n_old     = r_old;
        n_status  = r_status;
        n_res     = r_res;
        n_moved   = r_moved;
        n_copy    = r_copy;
        we        = 1'b0;
        wa        = r_k;
        wd        = '{size: r_sz, inv: 1'b0, start: r_st};
        case (i_cmd.op)
            OP_LOAD: begin
                n_off     = i_block_offset;
                n_sz      = SZ_W'(i_req_size) + SZ_W'(i_req_size[0]);
                n_idx     = '0;
                n_prev    = '0;
                n_cand    = '0;
                n_reuse_v = 1'b0;
                n_status  = (i_action == ACT_ALLOC || i_action == ACT_FREE ||
                             i_action == ACT_RESIZE) ? ST_OK : ST_NOT_FND;
                n_res     = '0;
                n_moved   = 1'b0;
                n_copy    = '0;
            end
            OP_FIND: begin
                if (!r_rd.inv && r_rd.start == {1'b0, r_off}) begin
                    n_k   = r_idx[IDX_W-1:0];
                    n_st  = r_rd.start;
                    n_old = r_rd.size;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            OP_FREE: begin
                we    = 1'b1;
                wd    = '{size: r_old, inv: 1'b1, start: r_st};
                n_res = r_off;
            end
            OP_SHRINK: begin
                we    = 1'b1;
                n_res = r_st[8:0];
            end
            OP_GROW: begin
                if (grow_fail) begin
                    n_status = ST_NO_SPACE;
                end else begin
                    if (e_grow > t_ar'(r_dend)) n_dend = POS_W'(e_grow);
                    we    = 1'b1;
                    n_res = r_st[8:0];
                end
            end
            OP_HSTART: n_jdx = '0;
            OP_HNEXT:  n_jdx = r_jdx + 1'b1;
            OP_ASTART: begin
                n_idx     = '0;
                n_prev    = '0;
                n_cand    = '0;
                n_reuse_v = 1'b0;
            end
            OP_AEV: begin
                n_idx = r_idx + 1'b1;
                if (r_rd.inv) begin
                    n_reuse_v = 1'b1;
                    n_reuse   = r_idx[IDX_W-1:0];
                    n_cand    = SZ_W'(r_rd.start);
                end else begin
                    if (fit) n_cand = r_prev;
                    n_prev = SZ_W'(r_rd.start) + r_rd.size;
                end
            end
            OP_APPEND: begin
                if (app_fail) begin
                    n_status = ST_NO_SPACE;
                    n_res    = '0;
                end else begin
                    we     = 1'b1;
                    wa     = r_reuse_v ? r_reuse : r_cnt[IDX_W-1:0];
                    wd     = '{size: r_sz, inv: 1'b0, start: r_dend};
                    n_dend = POS_W'(SZ_W'(r_dend) + r_sz);
                    n_cand = SZ_W'(r_dend);
                    n_res  = r_dend[8:0];
                    if (!r_reuse_v) n_cnt = r_cnt + 1'b1;
                end
            end
            OP_COMMIT: begin
                if (!r_reuse_v && cmt_fail) begin
                    n_status = ST_NO_SPACE;
                    n_res    = '0;
                end else begin
                    we    = 1'b1;
                    wa    = r_reuse_v ? r_reuse : r_cnt[IDX_W-1:0];
                    wd    = '{size: r_sz, inv: 1'b0, start: r_cand[POS_W-1:0]};
                    n_res = r_cand[8:0];
                    if (!r_reuse_v) n_cnt = r_cnt + 1'b1;
                end
            end
            OP_MOVEFIN: begin
                we      = 1'b1;
                wd      = '{size: r_old, inv: 1'b1, start: r_st};
                n_moved = 1'b1;
                n_copy  = r_old[9:0];
            end
            OP_NOTFOUND: n_status = ST_NOT_FND;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        r_rd <= r_mem[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dend <= '0;
        end else begin
            r_cnt  <= n_cnt;
            r_dend <= n_dend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_jdx     <= n_jdx;
        r_off     <= n_off;
        r_sz      <= n_sz;
        r_prev    <= n_prev;
        r_cand    <= n_cand;
        r_reuse_v <= n_reuse_v;
        r_reuse   <= n_reuse;
        r_k       <= n_k;
        r_st      <= n_st;
        r_old     <= n_old;
        r_status  <= n_status;
        r_res     <= n_res;
        r_moved   <= n_moved;
        r_copy    <= n_copy;
    end

    assign o_status        = r_status;
    assign o_result_offset = r_res;
    assign o_moved         = r_moved;
    assign o_copy_bytes    = r_copy;

endmodule
`default_nettype wire

### src/pool_block_allocator_top.sv
// An unknown action goes straight to the result with not-found status; a free reads
// descriptors one by one until it finds the block, and a plain append reads each
// descriptor once. Each gap check or overlap walk reads the descriptors again, so an
// allocate or a relocating resize grows with entry_count squared.
// One request at a time: o_stall stays high from acceptance until the result has been taken.
// Reset (synchronous, active low) empties the pool: entry count and data end 0.
`default_nettype none
module pool_block_allocator_top
    import pba_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_action,
    input  wire logic [8:0] i_block_offset,
    input  wire logic [9:0] i_req_size,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [1:0]      o_status,
    output logic [8:0]      o_result_offset,
    output logic            o_moved,
    output logic [9:0]      o_copy_bytes
);

    t_cmd  cmd;
    t_stat st;

    pba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_st     (st),
        .o_cmd    (cmd)
    );

    pba_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_block_offset  (i_block_offset),
        .i_req_size      (i_req_size),
        .o_st            (st),
        .o_status        (o_status),
        .o_result_offset (o_result_offset),
        .o_moved         (o_moved),
        .o_copy_bytes    (o_copy_bytes)
    );

endmodule
`default_nettype wire

### src/pba_checker.sv
`default_nettype none
module pba_checker
    import pba_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [1:0] o_status,
    input wire logic [8:0] o_result_offset,
    input wire logic       o_moved,
    input wire logic [9:0] o_copy_bytes
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_offset) && $stable(o_status))
        else $error("result changed while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |->
            o_result_offset == '0 && !o_moved && o_copy_bytes == '0)
        else $error("failed request carries payload");

    a_moved_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_moved |-> o_status == ST_OK && o_copy_bytes != '0 ||
            o_valid && o_moved && o_status == ST_OK)
        else $error("move reported on failure");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");

endmodule

bind pool_block_allocator_top pba_checker u_pba_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_result_offset (o_result_offset),
    .o_moved         (o_moved),
    .o_copy_bytes    (o_copy_bytes)
);
`default_nettype wire
